/* rtl/kps_pkg.sv */
// Shared constants and types for the k-mer position scatter block.
// No dependencies; every other file of the block imports this package.
package kps_pkg;

    // Default build-time sizes
    localparam int DEF_SEED_LEN   = 14;
    localparam int DEF_PART_CODES = 65536;

    // Field widths of the stream words
    localparam int MODE_W   = 2;
    localparam int IDX_IN_W = 16;
    localparam int VAL_W    = 32;
    localparam int BASE_W   = 2;
    localparam int POS_W    = 32;
    localparam int S_DATA_W = 56;   // 50 payload bits padded to whole bytes
    localparam int M_DATA_W = 64;

    // Configuration register file
    localparam int CFG_W    = 29;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic [CFG_W-1:0] BEGIN_RST = 29'd0;
    localparam logic [CFG_W-1:0] END_RST   = 29'd65536;
    localparam logic             REG_BEGIN = 1'b0;
    localparam logic             REG_END   = 1'b1;

    // Word kinds carried in tuser
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEQ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BASE = 2'd2;

    // Control travelling from the front stage to the cursor stage
    typedef struct packed {
        logic is_load;  // cursor table load, else a base
        logic full;     // a whole seed is present in the rolling code
    } t_s1_ctl;

endpackage

/* rtl/kps_apb_regs.sv */
// Partition bound registers behind an APB-style port.
// Depends on kps_pkg for widths, reset values and register indexes.
module kps_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kps_pkg::APB_AW-1:0]  paddr,
    input  logic [kps_pkg::APB_DW-1:0]  pwdata,
    output logic [kps_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [kps_pkg::CFG_W-1:0]   o_begin,
    output logic [kps_pkg::CFG_W-1:0]   o_end
);
    import kps_pkg::*;

    logic [CFG_W-1:0] r_begin;
    logic [CFG_W-1:0] r_end;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write the addressed register in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin <= BEGIN_RST;
            r_end   <= END_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_BEGIN) begin
                r_begin <= pwdata[CFG_W-1:0];
            end else begin
                r_end <= pwdata[CFG_W-1:0];
            end
        end
    end

    // Read back the addressed register
    always_comb begin
        if (paddr[2] == REG_BEGIN) begin
            prdata = APB_DW'(r_begin);
        end else begin
            prdata = APB_DW'(r_end);
        end
    end

    assign o_begin = r_begin;
    assign o_end   = r_end;

endmodule

/* rtl/kps_seed_front.sv */
// Front stage: rolling seed code, valid count and genome position.
// Depends on kps_pkg; feeds one registered word a cycle to kps_scatter_back on advance.
module kps_seed_front #(
    parameter int SEED_LEN = kps_pkg::DEF_SEED_LEN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic                          i_fire,
    input  logic [kps_pkg::MODE_W-1:0]    i_mode,
    input  logic [kps_pkg::IDX_IN_W-1:0]  i_idx,
    input  logic [kps_pkg::VAL_W-1:0]     i_value,
    input  logic [kps_pkg::BASE_W-1:0]    i_base,
    output logic                          o_s1_valid,
    output kps_pkg::t_s1_ctl              o_s1_ctl,
    output logic [2*SEED_LEN-1:0]         o_s1_code,
    output logic [kps_pkg::POS_W-1:0]     o_s1_pos,
    output logic [kps_pkg::IDX_IN_W-1:0]  o_s1_idx,
    output logic [kps_pkg::VAL_W-1:0]     o_s1_value
);
    import kps_pkg::*;

    localparam int CODE_W = 2 * SEED_LEN;
    localparam int CNT_W  = $clog2(SEED_LEN + 1);

    logic [CODE_W-1:0] r_code, n_code;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [POS_W-1:0]  r_gpos;
    logic              is_load, is_seq, is_base;

    logic              r_s1_valid;
    t_s1_ctl           r_s1_ctl;
    logic [CODE_W-1:0] r_s1_code;
    logic [POS_W-1:0]  r_s1_pos;
    logic [IDX_IN_W-1:0] r_s1_idx;
    logic [VAL_W-1:0]  r_s1_value;

    assign is_load = (i_mode == MODE_LOAD);
    assign is_seq  = (i_mode == MODE_SEQ);
    assign is_base = (i_mode == MODE_BASE);

    // Shift the new base in and count up to a full seed
    assign n_code = CODE_W'({r_code, i_base});
    assign n_cnt  = (r_cnt == CNT_W'(SEED_LEN)) ? r_cnt : r_cnt + 1'b1;

    // Sequence state: a sequence start clears code and count only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= '0;
            r_cnt  <= '0;
            r_gpos <= '0;
        end else if (i_fire) begin
            if (is_seq) begin
                r_code <= '0;
                r_cnt  <= '0;
            end else if (is_base) begin
                r_code <= n_code;
                r_cnt  <= n_cnt;
                r_gpos <= r_gpos + 1'b1;
            end
        end
    end

    // Stage register towards the cursor table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_advance) begin
            r_s1_valid <= i_fire && (is_load || is_base);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s1_ctl.is_load <= is_load;
            r_s1_ctl.full    <= (n_cnt == CNT_W'(SEED_LEN));
            r_s1_code        <= n_code;
            r_s1_pos         <= r_gpos - POS_W'(SEED_LEN - 1);
            r_s1_idx         <= i_idx;
            r_s1_value       <= i_value;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_ctl   = r_s1_ctl;
    assign o_s1_code  = r_s1_code;
    assign o_s1_pos   = r_s1_pos;
    assign o_s1_idx   = r_s1_idx;
    assign o_s1_value = r_s1_value;

endmodule

/* rtl/kps_scatter_back.sv */
// Cursor stage: partition check, cursor table read-modify-write, result word.
// Depends on kps_pkg; takes the front stage words from kps_seed_front.
module kps_scatter_back #(
    parameter int SEED_LEN   = kps_pkg::DEF_SEED_LEN,
    parameter int PART_CODES = kps_pkg::DEF_PART_CODES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [kps_pkg::CFG_W-1:0]     i_begin,
    input  logic [kps_pkg::CFG_W-1:0]     i_end,
    input  logic                          i_s1_valid,
    input  kps_pkg::t_s1_ctl              i_s1_ctl,
    input  logic [2*SEED_LEN-1:0]         i_s1_code,
    input  logic [kps_pkg::POS_W-1:0]     i_s1_pos,
    input  logic [kps_pkg::IDX_IN_W-1:0]  i_s1_idx,
    input  logic [kps_pkg::VAL_W-1:0]     i_s1_value,
    output logic                          o_advance,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [kps_pkg::M_DATA_W-1:0]  o_m_tdata
);
    import kps_pkg::*;

    localparam int CODE_W = 2 * SEED_LEN;
    localparam int CMP_W  = ((CODE_W > CFG_W) ? CODE_W : CFG_W) + 1;
    localparam int IDX_W  = (PART_CODES > 1) ? $clog2(PART_CODES) : 1;

    // Cursor table, undefined until loaded
    logic [VAL_W-1:0] mem [PART_CODES];

    logic [CMP_W-1:0] code_x, begin_x, end_x, local_x;
    logic             hit, load_ok, s1_hit, s1_load;
    logic [IDX_W-1:0] rd_addr;

    logic             r_s2_hit, r_s2_load;
    logic [IDX_W-1:0] r_s2_addr;
    logic [POS_W-1:0] r_s2_pos;
    logic [VAL_W-1:0] r_s2_value;
    logic [VAL_W-1:0] r_rd_data;

    logic             r_fw_valid;
    logic [IDX_W-1:0] r_fw_addr;
    logic [VAL_W-1:0] r_fw_data;

    logic [VAL_W-1:0] cur;
    logic             wr_en;
    logic [VAL_W-1:0] wr_data;

    logic             r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    // Partition window and table bounds
    assign code_x  = CMP_W'(i_s1_code);
    assign begin_x = CMP_W'(i_begin);
    assign end_x   = CMP_W'(i_end);
    assign local_x = code_x - begin_x;
    assign hit     = (code_x >= begin_x) && (code_x < end_x)
                     && (local_x < CMP_W'(PART_CODES));
    assign load_ok = (32'(i_s1_idx) < 32'(PART_CODES));

    assign s1_hit  = i_s1_valid && !i_s1_ctl.is_load && i_s1_ctl.full && hit;
    assign s1_load = i_s1_valid && i_s1_ctl.is_load && load_ok;
    assign rd_addr = i_s1_ctl.is_load ? IDX_W'(i_s1_idx) : local_x[IDX_W-1:0];

    // Stall only a result that meets a full, unread output word
    assign o_advance = !(r_s2_hit && r_out_valid && !i_m_tready);

    // Take the last write forward over the table read
    assign cur     = (r_fw_valid && (r_fw_addr == r_s2_addr)) ? r_fw_data : r_rd_data;
    assign wr_en   = o_advance && (r_s2_hit || r_s2_load);
    assign wr_data = r_s2_load ? r_s2_value : cur + 1'b1;

    // Table ports: one read and one write a cycle while o_advance is high
    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[r_s2_addr] <= wr_data;
        end
    end

    // Second stage and forwarding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_hit   <= 1'b0;
            r_s2_load  <= 1'b0;
            r_fw_valid <= 1'b0;
        end else if (o_advance) begin
            r_s2_hit   <= s1_hit;
            r_s2_load  <= s1_load;
            r_fw_valid <= r_s2_hit || r_s2_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_s2_addr  <= rd_addr;
            r_s2_pos   <= i_s1_pos;
            r_s2_value <= i_s1_value;
            r_fw_addr  <= r_s2_addr;
            r_fw_data  <= wr_data;
        end
    end

    // Output word: slot in the low half, position in the high half
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance && r_s2_hit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && r_s2_hit) begin
            r_out_data <= {r_s2_pos, cur};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

/* rtl/kmer_position_scatter_core.sv */
// Scatter pass of a k-mer seed counting sort.
// Channels: s_axis takes words, m_axis gives one result per matching seed.
// s_axis_tuser holds the word kind: cursor load, sequence start or base.
// Load the cursor table with one load word per entry before streaming bases;
// an entry must be loaded before any seed reads it.
// Throughput: one word per cycle, sustained while m_axis_tready is high, for
// any mix of kinds. The cursor table is read from the front stage word and
// written back from the second stage; the back-to-back case on one entry is
// served from a forwarding register. Path: a base word passes the front stage,
// second stage and output registers before its result is valid on m_axis.
// Stall: while m_axis_tready is low, words that give no result keep
// flowing; s_axis_tready drops only when a seed result meets a full output.
// Reset clears the rolling code, valid count, genome position, pipeline and
// the partition bounds (begin 0, end 65536). The cursor table is not cleared
// and no clearing pass runs; words are accepted right after reset.
// Configuration: partition_begin at address 0, partition_end at address 4,
// written by the user only while the stream is idle; the block does not check.
// Top level; depends on kps_pkg, kps_apb_regs, kps_seed_front, kps_scatter_back.
module kmer_position_scatter_core #(
    parameter int SEED_LEN   = kps_pkg::DEF_SEED_LEN,
    parameter int PART_CODES = kps_pkg::DEF_PART_CODES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tdata: cursor_index[15:0], cursor_value[47:16], base[49:48], zero pad
    input  logic [kps_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // tuser: mode[1:0]
    input  logic [kps_pkg::MODE_W-1:0]    s_axis_tuser,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: slot[31:0], position[63:32]
    output logic [kps_pkg::M_DATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kps_pkg::APB_AW-1:0]    paddr,
    input  logic [kps_pkg::APB_DW-1:0]    pwdata,
    output logic [kps_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import kps_pkg::*;

    logic [CFG_W-1:0]    part_begin, part_end;
    logic                advance, fire;
    logic                s1_valid;
    t_s1_ctl             s1_ctl;
    logic [2*SEED_LEN-1:0] s1_code;
    logic [POS_W-1:0]    s1_pos;
    logic [IDX_IN_W-1:0] s1_idx;
    logic [VAL_W-1:0]    s1_value;

    assign s_axis_tready = advance;
    assign fire          = s_axis_tvalid && advance;

    kps_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_begin (part_begin),
        .o_end   (part_end)
    );

    kps_seed_front #(
        .SEED_LEN (SEED_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_fire     (fire),
        .i_mode     (s_axis_tuser),
        .i_idx      (s_axis_tdata[15:0]),
        .i_value    (s_axis_tdata[47:16]),
        .i_base     (s_axis_tdata[49:48]),
        .o_s1_valid (s1_valid),
        .o_s1_ctl   (s1_ctl),
        .o_s1_code  (s1_code),
        .o_s1_pos   (s1_pos),
        .o_s1_idx   (s1_idx),
        .o_s1_value (s1_value)
    );

    kps_scatter_back #(
        .SEED_LEN   (SEED_LEN),
        .PART_CODES (PART_CODES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_begin    (part_begin),
        .i_end      (part_end),
        .i_s1_valid (s1_valid),
        .i_s1_ctl   (s1_ctl),
        .i_s1_code  (s1_code),
        .i_s1_pos   (s1_pos),
        .i_s1_idx   (s1_idx),
        .i_s1_value (s1_value),
        .o_advance  (advance),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

/* rtl/kps_checker.sv */
// Port-level checks for kmer_position_scatter_core, bound to the top level.
// Depends on kps_pkg; sees the top-level ports only.
module kps_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [kps_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kps_pkg::APB_AW-1:0]    paddr,
    input  logic [kps_pkg::APB_DW-1:0]    pwdata,
    input  logic [kps_pkg::APB_DW-1:0]    prdata
);
    import kps_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word changed while stalled");

    // Drop the output word at reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Accept whenever the output can take a word
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled with room at the output");

    // Read back the bound just written
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=>
        ((paddr != $past(paddr)) || (prdata == APB_DW'($past(pwdata[CFG_W-1:0])))))
        else $error("partition register read back wrong");

endmodule

bind kmer_position_scatter_core kps_checker u_kps_checker (.*);
